// ===== rtl/dwmpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Batch-minimum dual moving average: shared package
// Widths, register indexes and beat types used by the block and its units.
// ----------------------------------------------------------------------------
package dwmpa_pkg;

  localparam int MaxWindow  = 64;
  localparam int RingAw     = $clog2(MaxWindow);
  localparam int PriceBits  = 32;
  localparam int OutBits    = 32;
  localparam int SumBits    = PriceBits + RingAw;
  localparam int FillBits   = RingAw + 1;
  localparam int CfgBits    = 7;
  localparam int CfgIdxBits = 1;
  localparam int DivCntBits = $clog2(SumBits + 1);

  localparam logic [CfgIdxBits-1:0] CfgShortWindow = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgLongWindow  = CfgIdxBits'(1);

  localparam logic [CfgBits-1:0] ShortWindowRst = CfgBits'(5);
  localparam logic [CfgBits-1:0] LongWindowRst  = CfgBits'(20);

  typedef struct packed {
    logic [PriceBits-1:0] price;
    logic                 batch_end;
  } in_beat_t;

  typedef struct packed {
    logic [OutBits-1:0] short_average;
    logic [OutBits-1:0] long_average;
  } out_beat_t;

  typedef struct packed {
    logic                start;
    logic [SumBits-1:0]  dividend;
    logic [FillBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SumBits-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/dwmpa_div.sv =====
// ----------------------------------------------------------------------------
// Batch-minimum dual moving average: iterative divider
// Restoring division of a window sum by its fill count, one quotient bit a
// cycle. A start beat loads the operands; done pulses with the quotient.
// ----------------------------------------------------------------------------
module dwmpa_div import dwmpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [DivCntBits-1:0] cnt_q;
  logic [SumBits-1:0]    work_q;
  logic [FillBits-1:0]   rem_q;
  logic [FillBits-1:0]   dvs_q;
  logic [FillBits:0]     shifted;
  logic [FillBits:0]     trial;
  logic                  take;

  assign shifted = {rem_q, work_q[SumBits-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign take    = ~trial[FillBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntBits'(SumBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DivCntBits'(1);
      if (cnt_q == DivCntBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      work_q <= {work_q[SumBits-2:0], take};
      rem_q  <= take ? trial[FillBits-1:0] : shifted[FillBits-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = work_q;

endmodule

// ===== rtl/dual_window_min_price_average_top.sv =====
// ----------------------------------------------------------------------------
// Batch-minimum dual moving average: top level
// Tracks the minimum price of each batch and, at each batch end, pushes it
// into a short and a long window and returns both truncated averages.
// ----------------------------------------------------------------------------
// Input beats carry a Q16.16 price and a batch_end flag. A beat without
// batch_end only updates the batch minimum and leaves the block ready. A
// beat with batch_end pushes the minimum into both rings (an evict step
// drops the oldest entry of a full window, then a push step writes), then
// one shared divider forms each average in turn at one quotient bit a
// cycle. Such a beat yields one output beat.
// The result sits in an output register, so price beats are still taken
// while it waits. If an earlier result has not been taken when the next
// batch completes, the block holds its new result and stays not ready.
// The configuration port writes a window length at once; writing either
// length empties that window. Reset empties both windows, restores lengths
// of 5 and 20 and sets the batch minimum to all ones. No clearing pass.
// ----------------------------------------------------------------------------
module dual_window_min_price_average_top import dwmpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_wdata_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StEvict = 3'd1;
  localparam logic [2:0] StPush  = 3'd2;
  localparam logic [2:0] StDivS  = 3'd3;
  localparam logic [2:0] StWaitS = 3'd4;
  localparam logic [2:0] StDivL  = 3'd5;
  localparam logic [2:0] StWaitL = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  function automatic logic [FillBits-1:0] clamp_len(logic [CfgBits-1:0] v);
    logic [FillBits-1:0] r;
    if (v == '0) begin
      r = FillBits'(1);
    end else if (v > CfgBits'(MaxWindow)) begin
      r = FillBits'(MaxWindow);
    end else begin
      r = FillBits'(v);
    end
    return r;
  endfunction

  logic [2:0]           state_q, state_d;
  logic [CfgBits-1:0]   win_s_q, win_l_q;
  logic [PriceBits-1:0] min_q, min_next, push_q;
  logic [SumBits-1:0]   sum_s_q, sum_l_q;
  logic [FillBits-1:0]  fill_s_q, fill_l_q;
  logic [RingAw-1:0]    head_s_q, head_l_q;
  logic [FillBits-1:0]  len_s, len_l;
  logic [PriceBits-1:0] ring_s [MaxWindow];
  logic [PriceBits-1:0] ring_l [MaxWindow];
  logic [PriceBits-1:0] rd_s_q, rd_l_q;
  logic [RingAw-1:0]    wa_s, wa_l;
  logic [OutBits-1:0]   avg_s_q;
  logic                 out_valid_q;
  out_beat_t            out_q;
  logic                 in_acc;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign min_next   = (in_data_i.price < min_q) ? in_data_i.price : min_q;
  assign len_s      = clamp_len(win_s_q);
  assign len_l      = clamp_len(win_l_q);
  assign wa_s       = head_s_q + fill_s_q[RingAw-1:0];
  assign wa_l       = head_l_q + fill_l_q[RingAw-1:0];

  always_comb begin
    div_req.start    = (state_q == StDivS) || (state_q == StDivL);
    div_req.dividend = (state_q == StDivL) ? sum_l_q : sum_s_q;
    div_req.divisor  = (state_q == StDivL) ? fill_l_q : fill_s_q;
  end

  dwmpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc && in_data_i.batch_end) state_d = StEvict;
      StEvict: state_d = StPush;
      StPush:  state_d = StDivS;
      StDivS:  state_d = StWaitS;
      StWaitS: if (div_rsp.done) state_d = StDivL;
      StDivL:  state_d = StWaitL;
      StWaitL: if (div_rsp.done) state_d = StFin;
      StFin:   if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      win_s_q     <= ShortWindowRst;
      win_l_q     <= LongWindowRst;
      min_q       <= '1;
      sum_s_q     <= '0;
      sum_l_q     <= '0;
      fill_s_q    <= '0;
      fill_l_q    <= '0;
      head_s_q    <= '0;
      head_l_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgShortWindow) begin
          win_s_q  <= cfg_wdata_i;
          sum_s_q  <= '0;
          fill_s_q <= '0;
          head_s_q <= '0;
        end
        if (cfg_idx_i == CfgLongWindow) begin
          win_l_q  <= cfg_wdata_i;
          sum_l_q  <= '0;
          fill_l_q <= '0;
          head_l_q <= '0;
        end
      end
      if (in_acc) begin
        min_q <= in_data_i.batch_end ? '1 : min_next;
      end
      if (state_q == StEvict) begin
        if (fill_s_q >= len_s) begin
          sum_s_q  <= sum_s_q - SumBits'(rd_s_q);
          head_s_q <= head_s_q + RingAw'(1);
          fill_s_q <= len_s - FillBits'(1);
        end
        if (fill_l_q >= len_l) begin
          sum_l_q  <= sum_l_q - SumBits'(rd_l_q);
          head_l_q <= head_l_q + RingAw'(1);
          fill_l_q <= len_l - FillBits'(1);
        end
      end
      if (state_q == StPush) begin
        sum_s_q  <= sum_s_q + SumBits'(push_q);
        sum_l_q  <= sum_l_q + SumBits'(push_q);
        fill_s_q <= fill_s_q + FillBits'(1);
        fill_l_q <= fill_l_q + FillBits'(1);
      end
      if (state_q == StFin && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.batch_end) begin
      push_q <= min_next;
    end
    if (state_q == StPush) begin
      ring_s[wa_s] <= push_q;
      ring_l[wa_l] <= push_q;
    end
    rd_s_q <= ring_s[head_s_q];
    rd_l_q <= ring_l[head_l_q];
    if (state_q == StWaitS && div_rsp.done) begin
      avg_s_q <= div_rsp.quotient[OutBits-1:0];
    end
    if (state_q == StFin && (!out_valid_q || out_ready_i)) begin
      out_q.short_average <= avg_s_q;
      out_q.long_average  <= div_rsp.quotient[OutBits-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/dwmpa_chk.sv =====
// ----------------------------------------------------------------------------
// Batch-minimum dual moving average: port checker
// Watches the ports of the top level for handshake and sequencing faults.
// ----------------------------------------------------------------------------
module dwmpa_chk import dwmpa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_beat_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_beat_t             out_data_o
);

  // A result beat is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // A batch end starts the averaging work, so the block is busy next cycle.
  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.batch_end |=> !in_ready_o)
    else $error("ready after a batch end beat");

  // A plain price beat never holds the block up.
  a_price_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.batch_end |=> in_ready_o)
    else $error("not ready after a price beat");

  // A new result only appears at the end of the averaging work.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result beat without a batch end");

endmodule

bind dual_window_min_price_average_top dwmpa_chk u_dwmpa_chk (.*);

// ===== verif/tb_dual_window_min_price_average_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the batch-minimum dual moving average
// Price beats are queued by phase and driven with random gaps, while result
// beats are taken with random stalls. A local predictor tracks the batch
// minimum and both windows, including length clamping and the emptying of a
// window on every length write. Each result beat is compared with it.
// ----------------------------------------------------------------------------
module tb_dual_window_min_price_average_top;
  import dwmpa_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_beat_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_beat_t             out_data_o;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgBits-1:0]    cfg_wdata_i;

  dual_window_min_price_average_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  in_beat_t  pending_prices[$];
  out_beat_t expected_averages[$];

  logic [PriceBits-1:0] batch_low;
  logic [PriceBits-1:0] win_ring [2][MaxWindow];
  logic [SumBits-1:0]   win_sum  [2];
  int                   win_fill [2];
  int                   win_head [2];
  int                   win_len  [2];

  logic in_taken;
  int   idle_pct;
  int   error_count;
  int   beats_sent;
  int   averages_checked;
  int   window_writes;

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("Mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic predict_min_average(input in_beat_t beat);
    out_beat_t avg;
    int        w;
    int        pos;
    if (beat.price < batch_low) batch_low = beat.price;
    if (beat.batch_end) begin
      for (w = 0; w < 2; w++) begin
        if (win_fill[w] >= win_len[w]) begin
          win_sum[w]  = win_sum[w] - win_ring[w][win_head[w]];
          win_head[w] = (win_head[w] + 1) % MaxWindow;
          win_fill[w] = win_len[w] - 1;
        end
        pos = (win_head[w] + win_fill[w]) % MaxWindow;
        win_ring[w][pos] = batch_low;
        win_sum[w]  = win_sum[w] + batch_low;
        win_fill[w] = win_fill[w] + 1;
      end
      avg.short_average = OutBits'(win_sum[CfgShortWindow] / SumBits'(win_fill[CfgShortWindow]));
      avg.long_average  = OutBits'(win_sum[CfgLongWindow] / SumBits'(win_fill[CfgLongWindow]));
      expected_averages = {expected_averages, avg};
      batch_low = '1;
    end
  endtask

  task automatic check_averages(input out_beat_t got);
    out_beat_t want;
    if (expected_averages.size() == 0) begin
      report_mismatch($sformatf("result beat %0h/%0h with no batch outstanding",
                                got.short_average, got.long_average));
    end else begin
      want = expected_averages.pop_front();
      if (got.short_average !== want.short_average) begin
        report_mismatch($sformatf("short average %0h, expected %0h",
                                  got.short_average, want.short_average));
      end
      if (got.long_average !== want.long_average) begin
        report_mismatch($sformatf("long average %0h, expected %0h",
                                  got.long_average, want.long_average));
      end
      averages_checked++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        beats_sent++;
        predict_min_average(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        check_averages(out_data_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_prices.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_prices.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic queue_price(input logic [PriceBits-1:0] price, input logic last);
    in_beat_t beat;
    beat.price     = price;
    beat.batch_end = last;
    pending_prices = {pending_prices, beat};
  endtask

  function automatic logic [PriceBits-1:0] pick_price();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return PriceBits'($urandom_range(0, 255));
      end
      3, 4: begin
        return {16'hFFFF, 16'($urandom())};
      end
      default: begin
        return PriceBits'($urandom());
      end
    endcase
  endfunction

  // The final batch of a phase may be left open, so its minimum carries over.
  task automatic queue_random_prices(input int count, input int single_pct);
    int left;
    int len;
    int k;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 99) < single_pct) ? 1 : $urandom_range(2, 6);
      for (k = 0; k < len && left > 0; k++) begin
        queue_price(pick_price(), k == len - 1);
        left--;
      end
    end
  endtask

  task automatic settle_block();
    while (pending_prices.size() != 0 || in_valid_i || expected_averages.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= len;
    win_len[idx]  = (len == 0) ? 1 : (len > MaxWindow) ? MaxWindow : int'(len);
    win_sum[idx]  = '0;
    win_fill[idx] = 0;
    win_head[idx] = 0;
    window_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int k;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgShortWindow;
    cfg_wdata_i = '0;
    in_taken    = 1'b0;
    idle_pct    = 24;
    error_count = 0;
    beats_sent  = 0;
    averages_checked = 0;
    window_writes    = 0;
    batch_low   = '1;
    win_sum[CfgShortWindow]  = '0;
    win_sum[CfgLongWindow]   = '0;
    win_fill[CfgShortWindow] = 0;
    win_fill[CfgLongWindow]  = 0;
    win_head[CfgShortWindow] = 0;
    win_head[CfgLongWindow]  = 0;
    win_len[CfgShortWindow]  = int'(ShortWindowRst);
    win_len[CfgLongWindow]   = int'(LongWindowRst);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_price(32'h0000_0000, 1'b1);
    queue_price(32'hFFFF_FFFF, 1'b1);
    queue_price(32'hAAAA_AAAA, 1'b0);
    queue_price(32'h5555_5555, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b1);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h0001_0000, 1'b1);
    queue_price(32'h7FFF_FFFF, 1'b0);
    queue_price(32'h8000_0000, 1'b0);
    queue_price(32'h1234_5678, 1'b1);
    queue_price(32'h0000_0001, 1'b0);
    queue_price(32'h0000_0000, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b1);
    for (k = 0; k < 8; k++) begin
      queue_price(32'hFFFF_FFFF, 1'b1);
    end
    queue_price(32'h0000_0000, 1'b1);
    settle_block();

    write_window(CfgShortWindow, CfgBits'(1));
    write_window(CfgLongWindow, CfgBits'(64));
    for (k = 0; k < 70; k++) begin
      queue_price(32'hFFFF_FFFF, 1'b1);
    end
    queue_random_prices(250, 80);
    settle_block();

    idle_pct = 0;
    write_window(CfgShortWindow, CfgBits'(64));
    write_window(CfgLongWindow, CfgBits'(1));
    queue_random_prices(200, 70);
    settle_block();

    idle_pct = 24;
    write_window(CfgShortWindow, CfgBits'(0));
    write_window(CfgLongWindow, CfgBits'(127));
    queue_random_prices(160, 50);
    settle_block();

    write_window(CfgLongWindow, CfgBits'(127));
    queue_random_prices(120, 50);
    settle_block();

    write_window(CfgShortWindow, CfgBits'(127));
    write_window(CfgLongWindow, CfgBits'(0));
    queue_random_prices(150, 60);
    settle_block();

    write_window(CfgShortWindow, CfgBits'($urandom_range(0, 127)));
    write_window(CfgLongWindow, CfgBits'($urandom_range(0, 127)));
    queue_random_prices(200, 50);
    settle_block();

    $display("Sent %0d price beats and checked %0d batch averages.", beats_sent,
             averages_checked);
    $display("Window lengths were written %0d times, from 0 up to 127.", window_writes);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Run timed out with %0d batches outstanding.", expected_averages.size());
    $display("FAIL");
    $finish;
  end

endmodule
